// ===== rtl/core/lkv_pkg.sv =====
// shared constants, types and helpers of the lru key/value table
package lkv_pkg;

    localparam int ENTRIES       = 16;
    localparam int KEY_BITS      = 64;
    localparam int VALUE_BITS    = 32;

    localparam int MODE_W        = 2;
    localparam int KEY_FIELD_W   = 64;
    localparam int VALUE_FIELD_W = 32;
    localparam int MAX_W         = 5;
    localparam int OCC_W         = 5;

    localparam int KEY_W   = KEY_BITS;
    localparam int VAL_W   = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (MAX_W > CNT_W) ? MAX_W : CNT_W;

    localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(16);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic capture;
        logic commit;
        logic shift_all;
        logic shift_hit;
    } t_cell_ctl;

    // effective limit: zero acts as one, values above the depth saturate
    function automatic logic [CNT_W-1:0] limit_of(input logic [MAX_W-1:0] m);
        logic [CMP_W-1:0] mx;
        begin
            mx = CMP_W'(m);
            if (mx == '0) begin
                return CNT_W'(1);
            end
            if (mx > CMP_W'(ENTRIES)) begin
                return CNT_W'(ENTRIES);
            end
            return CNT_W'(mx);
        end
    endfunction

endpackage

// ===== rtl/core/lkv_in_if.sv =====
// request channel carrying one table operation
interface lkv_in_if;
    logic                                valid;
    logic                                ready;
    logic [lkv_pkg::MODE_W-1:0]          mode;
    logic [lkv_pkg::KEY_FIELD_W-1:0]     key;
    logic [lkv_pkg::VALUE_FIELD_W-1:0]   value;

    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

// ===== rtl/core/lkv_out_if.sv =====
// result channel carrying one table response
interface lkv_out_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [lkv_pkg::VALUE_FIELD_W-1:0]   value_out;
    logic [lkv_pkg::OCC_W-1:0]           occupancy;
    logic [lkv_pkg::OCC_W-1:0]           evicted_count;

    modport source (output valid, hit, value_out, occupancy, evicted_count, input ready);
    modport sink   (input valid, hit, value_out, occupancy, evicted_count, output ready);
endinterface

// ===== rtl/core/lkv_cfg_if.sv =====
// configuration write channel for the entry limit
interface lkv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [lkv_pkg::MAX_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/lru_key_value_table_unit.sv =====
// top level of the lru key/value table: sequencer, count and cell chain
//
// Fully associative key/value table kept as a chain of cells ordered by
// recency: cell 0 holds the most recent entry and the first occupancy cells
// are valid. Each request has an accept step and an update step: on the accept edge every cell
// compares the request key against its own entry and latches a match flag;
// in the following update cycle the match flags ripple through the chain,
// the hit entry (or a new key) moves into cell 0 while the cells ahead of it
// shift one place down, and the response is loaded into the output register.
// The update cycle waits while the output register still holds an untaken
// response, and ready stays low during it, so a new request is taken only
// after the previous one has committed. Evicting least-recent entries needs
// no separate step: they simply fall off the valid end of the chain when the
// count is cut back to the limit. Limit writes are taken at any time and
// apply to the next insert of a new key.
module lru_key_value_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkv_in_if.sink      i_in,
    lkv_out_if.source   o_out,
    lkv_cfg_if.sink     i_cfg
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state                                r_state;
    lkv_pkg::t_mode                        r_mode;
    logic [lkv_pkg::KEY_W-1:0]             r_key;
    logic [lkv_pkg::VAL_W-1:0]             r_value;
    logic [lkv_pkg::CNT_W-1:0]             r_count;
    logic [lkv_pkg::MAX_W-1:0]             r_max_entries;

    logic                                  r_out_valid;
    logic                                  r_out_hit;
    logic [lkv_pkg::VALUE_FIELD_W-1:0]     r_out_value;
    logic [lkv_pkg::CNT_W-1:0]             r_out_evicted;

    logic                                  accept;
    logic                                  commit;
    lkv_pkg::t_cell_ctl                    cell_ctl;

    logic [lkv_pkg::KEY_W-1:0]             chain_key   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::VAL_W-1:0]             chain_value [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0]           chain_below;
    logic [lkv_pkg::VAL_W-1:0]             chain_sel   [lkv_pkg::ENTRIES];
    logic [lkv_pkg::ENTRIES-1:0]           cell_valid;

    logic                                  hit_any;
    logic [lkv_pkg::VAL_W-1:0]             head_value;
    logic [lkv_pkg::CNT_W-1:0]             limit;
    logic                                  n_hit;
    logic [lkv_pkg::VALUE_FIELD_W-1:0]     n_out_value;
    logic [lkv_pkg::CNT_W-1:0]             n_count;
    logic [lkv_pkg::CNT_W-1:0]             n_evicted;
    logic                                  shift_all;
    logic                                  shift_hit;

    // handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign commit      = (r_state == S_UPDATE) && (!r_out_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_out_hit;
    assign o_out.value_out     = r_out_value;
    assign o_out.occupancy     = lkv_pkg::OCC_W'(r_count);
    assign o_out.evicted_count = lkv_pkg::OCC_W'(r_out_evicted);

    assign hit_any = chain_below[0];
    assign limit   = lkv_pkg::limit_of(r_max_entries);

    // operation decode, done in the update cycle
    always_comb begin
        n_hit       = 1'b0;
        n_out_value = '0;
        n_count     = r_count;
        n_evicted   = '0;
        shift_all   = 1'b0;
        shift_hit   = 1'b0;
        head_value  = r_value;
        case (r_mode)
            lkv_pkg::MODE_LOOKUP: begin
                n_hit      = hit_any;
                head_value = chain_sel[0];
                shift_hit  = 1'b1;
                if (hit_any) begin
                    n_out_value = lkv_pkg::VALUE_FIELD_W'(chain_sel[0]);
                end
            end
            lkv_pkg::MODE_INSERT: begin
                n_hit       = hit_any;
                n_out_value = lkv_pkg::VALUE_FIELD_W'(r_value);
                if (hit_any) begin
                    shift_hit = 1'b1;
                end else begin
                    // new key: oldest entries drop off the valid end
                    shift_all = 1'b1;
                    if (r_count >= limit) begin
                        n_evicted = r_count - limit + lkv_pkg::CNT_W'(1);
                        n_count   = limit;
                    end else begin
                        n_count   = r_count + lkv_pkg::CNT_W'(1);
                    end
                end
            end
            lkv_pkg::MODE_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        cell_ctl.capture   = accept;
        cell_ctl.commit    = commit;
        cell_ctl.shift_all = shift_all;
        cell_ctl.shift_hit = shift_hit;
    end

    // sequencer, count, request and response registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_max_entries <= lkv_pkg::MAX_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_entries <= i_cfg.data;
            end
            // response register: loaded on commit, emptied when taken
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_UPDATE;
                        r_mode  <= lkv_pkg::t_mode'(i_in.mode);
                        r_key   <= i_in.key[lkv_pkg::KEY_W-1:0];
                        r_value <= lkv_pkg::VAL_W'(i_in.value);
                    end
                end
                S_UPDATE: begin
                    if (commit) begin
                        r_state       <= S_IDLE;
                        r_count       <= n_count;
                        r_out_hit     <= n_hit;
                        r_out_value   <= n_out_value;
                        r_out_evicted <= n_evicted;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // cell chain: entries flow toward the tail, match info toward the head
    for (genvar g = 0; g < lkv_pkg::ENTRIES; g++) begin : g_cell
        logic [lkv_pkg::KEY_W-1:0] prev_key;
        logic [lkv_pkg::VAL_W-1:0] prev_value;
        logic                      below_in;
        logic [lkv_pkg::VAL_W-1:0] tail_value;

        assign cell_valid[g] = (r_count > lkv_pkg::CNT_W'(g));

        if (g == 0) begin : g_head
            assign prev_key   = r_key;
            assign prev_value = head_value;
        end else begin : g_body
            assign prev_key   = chain_key[g-1];
            assign prev_value = chain_value[g-1];
        end

        if (g == lkv_pkg::ENTRIES - 1) begin : g_tail
            assign below_in   = 1'b0;
            assign tail_value = '0;
        end else begin : g_link
            assign below_in   = chain_below[g+1];
            assign tail_value = chain_sel[g+1];
        end

        lkv_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_valid      (cell_valid[g]),
            .i_cmp_key    (i_in.key[lkv_pkg::KEY_W-1:0]),
            .i_prev_key   (prev_key),
            .i_prev_value (prev_value),
            .i_below      (below_in),
            .i_tail_value (tail_value),
            .o_key        (chain_key[g]),
            .o_value      (chain_value[g]),
            .o_below      (chain_below[g]),
            .o_sel_value  (chain_sel[g])
        );
    end

endmodule

// ===== rtl/core/lkv_cell.sv =====
// one recency slot of the table: stored pair, match flag and neighbor links
module lkv_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkv_pkg::t_cell_ctl           i_ctl,
    input  logic                         i_valid,
    input  logic [lkv_pkg::KEY_W-1:0]    i_cmp_key,
    input  logic [lkv_pkg::KEY_W-1:0]    i_prev_key,
    input  logic [lkv_pkg::VAL_W-1:0]    i_prev_value,
    input  logic                         i_below,
    input  logic [lkv_pkg::VAL_W-1:0]    i_tail_value,
    output logic [lkv_pkg::KEY_W-1:0]    o_key,
    output logic [lkv_pkg::VAL_W-1:0]    o_value,
    output logic                         o_below,
    output logic [lkv_pkg::VAL_W-1:0]    o_sel_value
);

    logic                         r_match;
    logic                         n_match;
    logic [lkv_pkg::KEY_W-1:0]    r_key;
    logic [lkv_pkg::VAL_W-1:0]    r_value;
    logic                         shift;

    assign n_match     = i_valid && (i_cmp_key == r_key);
    // a match here or further down the chain
    assign o_below     = i_below | r_match;
    assign o_sel_value = r_match ? r_value : i_tail_value;
    assign shift       = i_ctl.commit && (i_ctl.shift_all || (i_ctl.shift_hit && o_below));
    assign o_key       = r_key;
    assign o_value     = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.capture) begin
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

endmodule
